>>> hdl/esdu_pkg.sv
// ----------------------------------------------------------------------------
// esdu_pkg
// Shared types, constants and codes for the event surface decay update block.
// ----------------------------------------------------------------------------
package esdu_pkg;

    // Surface geometry; the surface is stored row by row.
    localparam int IMG_WIDTH   = 256;
    localparam int IMG_HEIGHT  = 256;
    localparam int PIX_COUNT   = IMG_WIDTH * IMG_HEIGHT;
    localparam int ADDR_W      = $clog2(PIX_COUNT);

    // Event word layout and coordinate arithmetic widths.
    localparam int COORD_W     = 11;
    localparam int COORD_CMP_W = 12;
    localparam int TYPE_W      = 4;
    localparam int KIDX_W      = 3;
    localparam int RAD_W       = 2;

    // Payload widths.
    localparam int FUNC_W      = 2;
    localparam int WORD_W      = 32;
    localparam int RD_COORD_W  = 8;
    localparam int PIX_W       = 8;
    localparam int SCALE_W     = 16;
    localparam int PROD_W      = PIX_W + SCALE_W;

    // Configuration port.
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = CFG_IDX_W'(1);

    // Register reset values and arithmetic constants.
    localparam logic [RAD_W-1:0]   RADIUS_RESET = RAD_W'(2);
    localparam logic [SCALE_W-1:0] SCALE_RESET  = SCALE_W'(62365);
    localparam logic [RAD_W-1:0]   RADIUS_SMALL = RAD_W'(1);
    localparam logic [RAD_W-1:0]   RADIUS_LARGE = RAD_W'(2);
    localparam logic [PIX_W-1:0]   PIX_FULL     = PIX_W'(255);
    localparam logic [PROD_W-1:0]  DECAY_ROUND  = PROD_W'(32768);

    // Polarity event types.
    localparam logic [TYPE_W-1:0]  EVT_TYPE_NEG = TYPE_W'(0);
    localparam logic [TYPE_W-1:0]  EVT_TYPE_POS = TYPE_W'(1);

    // Operation codes carried by a request transaction.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_EVENT = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    // Controller states.
    typedef enum logic [2:0] {
        ST_INIT_CLR,
        ST_IDLE,
        ST_EVT_CHECK,
        ST_SCAN,
        ST_DRAIN,
        ST_READ,
        ST_CLEAR,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic clr_en;
        logic kern_init;
        logic scan_en;
        logic rd_en;
        logic res_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_func func;
        logic  evt_ok;
        logic  clr_last;
        logic  scan_last;
        logic  pipe_busy;
        logic  out_free;
    } t_dp_sts;

endpackage

>>> hdl/esdu_in_if.sv
// ----------------------------------------------------------------------------
// esdu_in_if
// Request channel: valid/ready handshake with the operation payload.
// ----------------------------------------------------------------------------
interface esdu_in_if;
    logic                               valid;
    logic                               ready;
    logic [esdu_pkg::FUNC_W-1:0]        func;
    logic [esdu_pkg::WORD_W-1:0]        event_word;
    logic [esdu_pkg::RD_COORD_W-1:0]    read_col;
    logic [esdu_pkg::RD_COORD_W-1:0]    read_row;

    modport source (output valid, func, event_word, read_col, read_row, input ready);
    modport sink   (input valid, func, event_word, read_col, read_row, output ready);
endinterface

>>> hdl/esdu_out_if.sv
// ----------------------------------------------------------------------------
// esdu_out_if
// Response channel: valid/ready handshake with the result payload.
// ----------------------------------------------------------------------------
interface esdu_out_if;
    logic                         valid;
    logic                         ready;
    logic [esdu_pkg::PIX_W-1:0]   pixel_value;
    logic                         event_applied;

    modport source (output valid, pixel_value, event_applied, input ready);
    modport sink   (input valid, pixel_value, event_applied, output ready);
endinterface

>>> hdl/esdu_ctrl.sv
// ----------------------------------------------------------------------------
// esdu_ctrl
// Controller state machine: sequences clearing sweeps, kernel scans, pixel
// reads and the hand-off of each result to the output register.
// ----------------------------------------------------------------------------
module esdu_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  esdu_pkg::t_dp_sts i_sts,
    output esdu_pkg::t_dp_cmd o_cmd
);

    esdu_pkg::t_state r_state;
    esdu_pkg::t_state n_state;

    // State register; reset starts the initial clearing sweep.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= esdu_pkg::ST_INIT_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            esdu_pkg::ST_INIT_CLR: begin
                if (i_sts.clr_last) n_state = esdu_pkg::ST_IDLE;
            end
            esdu_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_sts.func)
                        esdu_pkg::FUNC_EVENT: n_state = esdu_pkg::ST_EVT_CHECK;
                        esdu_pkg::FUNC_READ:  n_state = esdu_pkg::ST_READ;
                        esdu_pkg::FUNC_CLEAR: n_state = esdu_pkg::ST_CLEAR;
                        default:              n_state = esdu_pkg::ST_DONE;
                    endcase
                end
            end
            esdu_pkg::ST_EVT_CHECK: begin
                n_state = i_sts.evt_ok ? esdu_pkg::ST_SCAN : esdu_pkg::ST_DONE;
            end
            esdu_pkg::ST_SCAN: begin
                if (i_sts.scan_last) n_state = esdu_pkg::ST_DRAIN;
            end
            esdu_pkg::ST_DRAIN: begin
                if (!i_sts.pipe_busy) n_state = esdu_pkg::ST_DONE;
            end
            esdu_pkg::ST_READ: begin
                n_state = esdu_pkg::ST_DONE;
            end
            esdu_pkg::ST_CLEAR: begin
                if (i_sts.clr_last) n_state = esdu_pkg::ST_DONE;
            end
            esdu_pkg::ST_DONE: begin
                if (i_sts.out_free) n_state = esdu_pkg::ST_IDLE;
            end
            default: n_state = esdu_pkg::ST_IDLE;
        endcase
    end

    // Output decode.
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            esdu_pkg::ST_INIT_CLR:  o_cmd.clr_en = 1'b1;
            esdu_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            esdu_pkg::ST_EVT_CHECK: o_cmd.kern_init = i_sts.evt_ok;
            esdu_pkg::ST_SCAN:      o_cmd.scan_en   = 1'b1;
            esdu_pkg::ST_DRAIN:     o_cmd           = '0;
            esdu_pkg::ST_READ:      o_cmd.rd_en     = 1'b1;
            esdu_pkg::ST_CLEAR:     o_cmd.clr_en    = 1'b1;
            esdu_pkg::ST_DONE:      o_cmd.res_load  = i_sts.out_free;
            default:                o_cmd           = '0;
        endcase
    end

endmodule

>>> hdl/esdu_dpath.sv
// ----------------------------------------------------------------------------
// esdu_dpath
// Datapath: configuration registers, surface memory, kernel address counters,
// the read / multiply / write-back decay pipeline and the result register.
// ----------------------------------------------------------------------------
module esdu_dpath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration port.
    input  logic                                i_cfg_we,
    input  logic [esdu_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [esdu_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Request payload.
    input  logic [esdu_pkg::FUNC_W-1:0]         i_in_func,
    input  logic [esdu_pkg::WORD_W-1:0]         i_in_word,
    input  logic [esdu_pkg::RD_COORD_W-1:0]     i_in_col,
    input  logic [esdu_pkg::RD_COORD_W-1:0]     i_in_row,
    // Response register.
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [esdu_pkg::PIX_W-1:0]          o_out_pix,
    output logic                                o_out_applied,
    // Controller link.
    input  esdu_pkg::t_dp_cmd                   i_cmd,
    output esdu_pkg::t_dp_sts                   o_sts
);

    localparam int AW = esdu_pkg::ADDR_W;

    // Configuration registers.
    logic [esdu_pkg::RAD_W-1:0]       r_radius;
    logic [esdu_pkg::SCALE_W-1:0]     r_scale;

    // Captured request.
    esdu_pkg::t_func                  r_func;
    logic [esdu_pkg::WORD_W-1:0]      r_word;
    logic [esdu_pkg::RD_COORD_W-1:0]  r_col;
    logic [esdu_pkg::RD_COORD_W-1:0]  r_row;
    logic                             r_applied;

    // Kernel scan counters.
    logic [esdu_pkg::KIDX_W-1:0]      r_kx;
    logic [esdu_pkg::KIDX_W-1:0]      r_ky;

    // Clearing sweep address.
    logic [AW-1:0]                    r_clr_addr;

    // Surface memory and its registered read data.
    logic [esdu_pkg::PIX_W-1:0]       r_mem [esdu_pkg::PIX_COUNT];
    logic [esdu_pkg::PIX_W-1:0]       r_rd_data;

    // Decay pipeline.
    logic                             r_p1_valid;
    logic [AW-1:0]                    r_p1_addr;
    logic                             r_p1_centre;
    logic                             r_p2_valid;
    logic [AW-1:0]                    r_p2_addr;
    logic                             r_p2_centre;
    logic [esdu_pkg::PROD_W-1:0]      r_p2_prod;

    // Result register.
    logic                             r_out_valid;
    logic [esdu_pkg::PIX_W-1:0]       r_out_pix;
    logic                             r_out_applied;

    logic [esdu_pkg::RAD_W-1:0]       rad;
    logic [esdu_pkg::KIDX_W-1:0]      span;
    logic [esdu_pkg::TYPE_W-1:0]      evt_type;
    logic [esdu_pkg::COORD_W-1:0]     evt_x;
    logic [esdu_pkg::COORD_W-1:0]     evt_y;
    logic [esdu_pkg::COORD_W-1:0]     k_col;
    logic [esdu_pkg::COORD_W-1:0]     k_row;
    logic [AW-1:0]                    kern_addr;
    logic [AW-1:0]                    read_addr;
    logic [AW-1:0]                    rd_addr;
    logic [AW-1:0]                    wr_addr;
    logic [esdu_pkg::PIX_W-1:0]       wr_data;
    logic [esdu_pkg::PROD_W-1:0]      rounded;
    logic                             mem_we;
    logic                             mem_re;
    logic                             type_ok;
    logic                             x_ok;
    logic                             y_ok;
    logic                             rd_ok;
    logic                             centre;
    logic                             kx_last;
    logic                             ky_last;
    logic                             clr_last;
    logic                             out_free;
    logic [esdu_pkg::PIX_W-1:0]       res_pix;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= esdu_pkg::RADIUS_RESET;
            r_scale  <= esdu_pkg::SCALE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                esdu_pkg::CFG_RADIUS: r_radius <= i_cfg_data[esdu_pkg::RAD_W-1:0];
                esdu_pkg::CFG_SCALE:  r_scale  <= i_cfg_data[esdu_pkg::SCALE_W-1:0];
                default: begin
                    r_radius <= r_radius;
                end
            endcase
        end
    end

    // Radius 1 gives the 3x3 kernel, every other code the 5x5 kernel.
    assign rad  = (r_radius == esdu_pkg::RADIUS_SMALL) ? esdu_pkg::RADIUS_SMALL
                                                       : esdu_pkg::RADIUS_LARGE;
    assign span = {rad, 1'b0};

    // Event decode and border check.
    assign evt_type = r_word[31:28];
    assign evt_x    = r_word[21:11];
    assign evt_y    = r_word[10:0];
    assign type_ok  = (evt_type == esdu_pkg::EVT_TYPE_NEG)
                   || (evt_type == esdu_pkg::EVT_TYPE_POS);
    assign x_ok     = (evt_x >= esdu_pkg::COORD_W'(rad))
                   && ((esdu_pkg::COORD_CMP_W'(evt_x) + esdu_pkg::COORD_CMP_W'(rad))
                       < esdu_pkg::COORD_CMP_W'(esdu_pkg::IMG_WIDTH));
    assign y_ok     = (evt_y >= esdu_pkg::COORD_W'(rad))
                   && ((esdu_pkg::COORD_CMP_W'(evt_y) + esdu_pkg::COORD_CMP_W'(rad))
                       < esdu_pkg::COORD_CMP_W'(esdu_pkg::IMG_HEIGHT));

    // Read request range check.
    assign rd_ok = (esdu_pkg::COORD_CMP_W'(r_col) < esdu_pkg::COORD_CMP_W'(esdu_pkg::IMG_WIDTH))
                && (esdu_pkg::COORD_CMP_W'(r_row) < esdu_pkg::COORD_CMP_W'(esdu_pkg::IMG_HEIGHT));

    // Request capture and result flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_func    <= esdu_pkg::FUNC_NONE;
            r_applied <= 1'b0;
        end else if (i_cmd.load) begin
            r_func    <= esdu_pkg::t_func'(i_in_func);
            r_applied <= 1'b0;
        end else if (i_cmd.kern_init) begin
            r_applied <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_word <= i_in_word;
            r_col  <= i_in_col;
            r_row  <= i_in_row;
        end
    end

    // Kernel position counters: column inner, row outer.
    assign kx_last = (r_kx == span);
    assign ky_last = (r_ky == span);
    assign centre  = (r_kx == esdu_pkg::KIDX_W'(rad)) && (r_ky == esdu_pkg::KIDX_W'(rad));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kx <= '0;
            r_ky <= '0;
        end else if (i_cmd.kern_init) begin
            r_kx <= '0;
            r_ky <= '0;
        end else if (i_cmd.scan_en) begin
            if (kx_last) begin
                r_kx <= '0;
                r_ky <= r_ky + 1'b1;
            end else begin
                r_kx <= r_kx + 1'b1;
            end
        end
    end

    // Kernel pixel address; the border check keeps it inside the image.
    assign k_col     = evt_x + esdu_pkg::COORD_W'(r_kx) - esdu_pkg::COORD_W'(rad);
    assign k_row     = evt_y + esdu_pkg::COORD_W'(r_ky) - esdu_pkg::COORD_W'(rad);
    assign kern_addr = AW'(k_row) * AW'(esdu_pkg::IMG_WIDTH) + AW'(k_col);
    assign read_addr = AW'(r_row) * AW'(esdu_pkg::IMG_WIDTH) + AW'(r_col);

    // Clearing sweep, one pixel per cycle.
    assign clr_last = (r_clr_addr == AW'(esdu_pkg::PIX_COUNT - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_en) begin
            r_clr_addr <= clr_last ? '0 : r_clr_addr + 1'b1;
        end
    end

    // Memory port selection: sweep writes and pipeline write-back never overlap.
    assign rounded = r_p2_prod + esdu_pkg::DECAY_ROUND;
    assign rd_addr = i_cmd.rd_en ? read_addr : kern_addr;
    assign mem_re  = i_cmd.rd_en || i_cmd.scan_en;
    assign mem_we  = i_cmd.clr_en || r_p2_valid;
    assign wr_addr = i_cmd.clr_en ? r_clr_addr : r_p2_addr;
    assign wr_data = i_cmd.clr_en ? '0
                   : (r_p2_centre ? esdu_pkg::PIX_FULL
                                  : rounded[esdu_pkg::PROD_W-1:esdu_pkg::SCALE_W]);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Decay pipeline: read, multiply, write back. Kernel addresses are distinct.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
        end else begin
            r_p1_valid <= i_cmd.scan_en;
            r_p2_valid <= r_p1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_addr   <= kern_addr;
        r_p1_centre <= centre;
        r_p2_addr   <= r_p1_addr;
        r_p2_centre <= r_p1_centre;
        r_p2_prod   <= esdu_pkg::PROD_W'(r_rd_data) * esdu_pkg::PROD_W'(r_scale);
    end

    // Result register; it frees up when the consumer takes the transaction.
    assign out_free = !r_out_valid || i_out_ready;
    assign res_pix  = ((r_func == esdu_pkg::FUNC_READ) && rd_ok) ? r_rd_data : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_out_pix     <= res_pix;
            r_out_applied <= r_applied;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_pix     = r_out_pix;
    assign o_out_applied = r_out_applied;

    // Status back to the controller.
    assign o_sts.func      = esdu_pkg::t_func'(i_in_func);
    assign o_sts.evt_ok    = type_ok && x_ok && y_ok;
    assign o_sts.clr_last  = clr_last;
    assign o_sts.scan_last = kx_last && ky_last;
    assign o_sts.pipe_busy = r_p1_valid || r_p2_valid;
    assign o_sts.out_free  = out_free;

endmodule

>>> hdl/event_surface_decay_update.sv
// Throughput: one transaction at a time; the kernel scan sets the rate with
// one surface pixel read per cycle through a three-stage read/scale/write loop.
// Reset: synchronous, active low; afterwards a clearing sweep zeroes every pixel
// with the request channel not ready (configuration writes are still taken).
// ----------------------------------------------------------------------------
// event_surface_decay_update
// Event surface with decaying kernel neighborhood, pixel read-back and clear.
// ----------------------------------------------------------------------------
module event_surface_decay_update (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [esdu_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [esdu_pkg::CFG_DATA_W-1:0] i_cfg_data,
    esdu_in_if.sink                         i_req,
    esdu_out_if.source                      o_rsp
);

    esdu_pkg::t_dp_cmd cmd;
    esdu_pkg::t_dp_sts sts;
    logic              in_ready;

    // Controller.
    esdu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath.
    esdu_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_func     (i_req.func),
        .i_in_word     (i_req.event_word),
        .i_in_col      (i_req.read_col),
        .i_in_row      (i_req.read_row),
        .o_out_valid   (o_rsp.valid),
        .i_out_ready   (o_rsp.ready),
        .o_out_pix     (o_rsp.pixel_value),
        .o_out_applied (o_rsp.event_applied),
        .i_cmd         (cmd),
        .o_sts         (sts)
    );

    assign i_req.ready = in_ready;

endmodule

>>> hdl/esdu_checker.sv
// ----------------------------------------------------------------------------
// esdu_checker
// Port-level checks on the event surface decay update block.
// ----------------------------------------------------------------------------
module esdu_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [esdu_pkg::PIX_W-1:0]   i_out_pix,
    input logic                         i_out_applied
);

    // A pending response transaction holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_pix)
                                        && $stable(i_out_applied))
        else $error("response changed while stalled");

    // Requests are processed one at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request accepted back to back");

    // An applied event never reports a pixel value.
    a_applied_pix_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_applied |-> i_out_pix == '0)
        else $error("applied event carries a pixel value");

    // Reset empties the response register and starts the clearing sweep.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && !i_in_ready)
        else $error("channels active right after reset");

endmodule

bind event_surface_decay_update esdu_checker u_esdu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_req.valid),
    .i_in_ready    (i_req.ready),
    .i_out_valid   (o_rsp.valid),
    .i_out_ready   (o_rsp.ready),
    .i_out_pix     (o_rsp.pixel_value),
    .i_out_applied (o_rsp.event_applied)
);
